[sv/drc_pkg.sv]
// shared types, constants and a helper for the discovery reply table
`timescale 1ns / 1ps
`default_nettype none
package drc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_DATAGRAM  = 64;
    localparam int MIN_REPLY     = 10;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

    localparam logic [1:0] CFG_VERSION  = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_FORGET   = 2'd2;

    localparam logic [7:0]  RST_VERSION  = 8'd1;
    localparam logic [15:0] RST_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_FORGET   = 16'd4000;

    localparam logic [2:0] KIND_PROBE     = 3'd0;
    localparam logic [2:0] KIND_ADDED     = 3'd1;
    localparam logic [2:0] KIND_REFRESHED = 3'd2;
    localparam logic [2:0] KIND_FORGOTTEN = 3'd3;
    localparam logic [2:0] KIND_REJECTED  = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REP_CHECK,
        ST_REP_SCAN,
        ST_REP_WRITE,
        ST_REP_EMIT,
        ST_TICK_SCAN,
        ST_TICK_FLUSH
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] host;
        logic [15:0] port;
        logic [21:0] counts;
        logic [15:0] age;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] host;
        logic [15:0] port;
        logic [21:0] counts;
        logic        last;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] p);
        logic [7:0] b;
        case (p)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h4E;
            2'd2:    b = 8'h46;
            default: b = 8'h52;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[sv/drc_cell.sv]
// one table entry cell of the rotating entry chain
`timescale 1ns / 1ps
`default_nettype none
module drc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire drc_pkg::t_entry i_entry,
    output drc_pkg::t_entry      o_entry
);

    logic            r_valid;
    drc_pkg::t_entry r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_entry;
        end
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule
`default_nettype wire

[sv/discovery_reply_table_with_aging.sv]
// top level: reply parser, controller and chain of table cells
// a non-final byte is taken in idle; a final byte runs a check, then a scan pass
// and a write pass round the cell chain, then emits; rejects go from check to emit
// a tick runs a scan pass and a flush, one chain rotation per cycle unless output stalls
// one item at a time; the result register lets the next item enter while a word waits
// synchronous active-low reset empties the table, sets probe due and clears the parser
`timescale 1ns / 1ps
`default_nettype none
module discovery_reply_table_with_aging (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_source_addr,
    input  wire logic        i_last_byte,
    input  wire logic [15:0] i_elapsed_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [3:0]       o_slot,
    output logic [31:0]      o_host_addr,
    output logic [15:0]      o_game_port,
    output logic [7:0]       o_humans,
    output logic [7:0]       o_capacity,
    output logic [5:0]       o_name_length,
    output logic             o_last
);

    localparam int N = drc_pkg::TABLE_ENTRIES;
    localparam int IW = drc_pkg::IDX_W;
    localparam int PW = drc_pkg::POS_W;

    drc_pkg::t_state  r_state, n_state;
    logic [7:0]       r_version;
    logic [15:0]      r_interval, r_forget, r_timer, r_dt;
    logic [PW-1:0]    r_pos;
    logic [7:0]       r_held [6];
    logic             r_magic_bad;
    logic [31:0]      r_src;
    logic             r_rep_ok;
    logic [15:0]      r_rep_port;
    logic [21:0]      r_rep_counts;
    logic             r_found, r_free_v;
    logic [IW-1:0]    r_hit, r_free, r_idx;
    logic             r_pend_v, r_out_v;
    drc_pkg::t_result r_pend, r_out;

    drc_pkg::t_entry  ents [N];
    drc_pkg::t_entry  head, head_in;
    logic             shift, load_out, out_free, accept, idx_last;
    logic             forget, tick_step, do_write, chk_ok;
    logic [16:0]      age_sum, tim_sum;
    logic [15:0]      age_sat, tim_sat;
    logic [IW-1:0]    target;
    drc_pkg::t_result out_next, rep_result, forgot_result;
    logic [7:0]       room, name_clip;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            drc_pkg::t_entry cin;
            if (g == N - 1) begin : g_tail
                assign cin = head_in;
            end else begin : g_mid
                assign cin = ents[g+1];
            end
            drc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_entry (cin),
                .o_entry (ents[g])
            );
        end
    endgenerate

    assign head        = ents[0];
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == drc_pkg::ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_v || i_out_ready;
    assign idx_last    = (r_idx == IW'(N - 1));

    assign age_sum   = {1'b0, head.age} + {1'b0, r_dt};
    assign age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign forget    = head.valid && (age_sat > r_forget);
    assign tick_step = !forget || !r_pend_v || out_free;
    assign tim_sum   = {1'b0, r_timer} + {1'b0, i_elapsed_ms};
    assign tim_sat   = tim_sum[16] ? 16'hFFFF : tim_sum[15:0];

    assign room      = 8'(r_pos) - 8'(drc_pkg::MIN_REPLY);
    assign name_clip = (r_held[5] > room) ? room : r_held[5];
    assign chk_ok    = (r_pos >= PW'(drc_pkg::MIN_REPLY)) && !r_magic_bad
                       && (r_held[0] == r_version);

    assign do_write = r_found || r_free_v;
    assign target   = r_found ? r_hit : r_free;

    always_comb begin
        rep_result.host   = r_src;
        rep_result.port   = r_rep_port;
        rep_result.counts = r_rep_counts;
        rep_result.last   = 1'b1;
        rep_result.slot   = 4'(target);
        if (!r_rep_ok) begin
            rep_result.kind   = drc_pkg::KIND_REJECTED;
            rep_result.slot   = 4'd0;
            rep_result.port   = 16'd0;
            rep_result.counts = 22'd0;
        end else if (r_found) begin
            rep_result.kind = drc_pkg::KIND_REFRESHED;
        end else if (r_free_v) begin
            rep_result.kind = drc_pkg::KIND_ADDED;
        end else begin
            rep_result.kind = drc_pkg::KIND_FULL;
            rep_result.slot = 4'd0;
        end
        forgot_result.kind   = drc_pkg::KIND_FORGOTTEN;
        forgot_result.slot   = 4'(r_idx);
        forgot_result.host   = head.host;
        forgot_result.port   = head.port;
        forgot_result.counts = head.counts;
        forgot_result.last   = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            drc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd) begin
                        n_state = drc_pkg::ST_TICK_SCAN;
                    end else if (i_last_byte) begin
                        n_state = drc_pkg::ST_REP_CHECK;
                    end
                end
            end
            drc_pkg::ST_REP_CHECK: begin
                n_state = chk_ok ? drc_pkg::ST_REP_SCAN : drc_pkg::ST_REP_EMIT;
            end
            drc_pkg::ST_REP_SCAN: begin
                if (idx_last) n_state = drc_pkg::ST_REP_WRITE;
            end
            drc_pkg::ST_REP_WRITE: begin
                if (idx_last) n_state = drc_pkg::ST_REP_EMIT;
            end
            drc_pkg::ST_REP_EMIT: begin
                if (out_free) n_state = drc_pkg::ST_IDLE;
            end
            drc_pkg::ST_TICK_SCAN: begin
                if (tick_step && idx_last) n_state = drc_pkg::ST_TICK_FLUSH;
            end
            drc_pkg::ST_TICK_FLUSH: begin
                if (!r_pend_v || out_free) n_state = drc_pkg::ST_IDLE;
            end
            default: n_state = drc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        shift         = 1'b0;
        head_in       = head;
        load_out      = 1'b0;
        out_next      = r_pend;
        out_next.last = 1'b0;
        case (r_state)
            drc_pkg::ST_REP_SCAN: shift = 1'b1;
            drc_pkg::ST_REP_WRITE: begin
                shift = 1'b1;
                if (do_write && (r_idx == target)) begin
                    head_in.valid  = 1'b1;
                    head_in.host   = r_src;
                    head_in.port   = r_rep_port;
                    head_in.counts = r_rep_counts;
                    head_in.age    = 16'd0;
                end
            end
            drc_pkg::ST_REP_EMIT: begin
                load_out = out_free;
                out_next = rep_result;
            end
            drc_pkg::ST_TICK_SCAN: begin
                if (tick_step) begin
                    shift       = 1'b1;
                    head_in.age = age_sat;
                    if (forget) begin
                        head_in.valid = 1'b0;
                        load_out      = r_pend_v;
                    end
                end
            end
            drc_pkg::ST_TICK_FLUSH: begin
                load_out      = r_pend_v && out_free;
                out_next.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drc_pkg::ST_IDLE;
            r_version   <= drc_pkg::RST_VERSION;
            r_interval  <= drc_pkg::RST_INTERVAL;
            r_forget    <= drc_pkg::RST_FORGET;
            r_timer     <= 16'hFFFF;
            r_pos       <= '0;
            r_magic_bad <= 1'b0;
            r_idx       <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            for (int j = 0; j < 6; j++) r_held[j] <= 8'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    drc_pkg::CFG_VERSION:  r_version  <= i_cfg_data[7:0];
                    drc_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                    drc_pkg::CFG_FORGET:   r_forget   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && !i_cmd && (r_pos < PW'(drc_pkg::MAX_DATAGRAM))) begin
                if (r_pos < PW'(4)) begin
                    if (i_data_byte != drc_pkg::magic_byte(r_pos[1:0])) r_magic_bad <= 1'b1;
                end
                for (int j = 0; j < 6; j++) begin
                    if (r_pos == PW'(j + 4)) r_held[j] <= i_data_byte;
                end
                r_pos <= r_pos + PW'(1);
            end
            if (accept && i_cmd) begin
                if (tim_sat >= r_interval) begin
                    r_timer  <= 16'd0;
                    r_pend_v <= 1'b1;
                end else begin
                    r_timer  <= tim_sat;
                    r_pend_v <= 1'b0;
                end
            end
            if (r_state == drc_pkg::ST_REP_CHECK) begin
                r_pos       <= '0;
                r_magic_bad <= 1'b0;
                for (int j = 0; j < 6; j++) r_held[j] <= 8'd0;
            end
            if (shift) r_idx <= idx_last ? '0 : r_idx + IW'(1);
            if (r_state == drc_pkg::ST_TICK_SCAN && shift && forget) r_pend_v <= 1'b1;
            if (r_state == drc_pkg::ST_TICK_FLUSH && out_free) r_pend_v <= 1'b0;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src <= i_source_addr;
            r_dt  <= i_elapsed_ms;
        end
        if (accept && i_cmd) begin
            r_pend <= '{kind: drc_pkg::KIND_PROBE, default: '0};
        end
        if (r_state == drc_pkg::ST_TICK_SCAN && shift && forget) r_pend <= forgot_result;
        if (r_state == drc_pkg::ST_REP_CHECK) begin
            r_rep_ok     <= chk_ok;
            r_rep_port   <= {r_held[2], r_held[1]};
            r_rep_counts <= {name_clip[5:0], r_held[4], r_held[3]};
            r_found      <= 1'b0;
            r_free_v     <= 1'b0;
        end
        if (r_state == drc_pkg::ST_REP_SCAN) begin
            if (head.valid && head.host == r_src && head.port == r_rep_port && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= r_idx;
            end
            if (!head.valid && !r_free_v) begin
                r_free_v <= 1'b1;
                r_free   <= r_idx;
            end
        end
        if (load_out) r_out <= out_next;
    end

    assign o_out_valid   = r_out_v;
    assign o_kind        = r_out.kind;
    assign o_slot        = r_out.slot;
    assign o_host_addr   = r_out.host;
    assign o_game_port   = r_out.port;
    assign o_humans      = r_out.counts[7:0];
    assign o_capacity    = r_out.counts[15:8];
    assign o_name_length = r_out.counts[21:16];
    assign o_last        = r_out.last;

`ifndef NO_ASSERTIONS
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == drc_pkg::ST_IDLE |-> !r_pend_v && r_idx == '0)
        else $error("pending result or chain position left over in idle");
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drc_pkg::ST_REP_EMIT && out_free) |=> o_out_valid && o_last)
        else $error("reply result not delivered as final word");
    a_scan_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drc_pkg::ST_REP_SCAN && idx_last) |=> r_state == drc_pkg::ST_REP_WRITE
        && r_idx == '0)
        else $error("scan pass did not wrap the chain");
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drc_pkg::ST_TICK_FLUSH && r_pend_v && out_free) |=> o_last)
        else $error("tick ended without final flag");
`endif

endmodule
`default_nettype wire
